>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

>>> rtl/ffp_pkg.sv
// ----------------------------------------------------------------------------
// File frame parser package
// Beat types, field kinds, status codes and constants shared by the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffp_pkg;

  // Reset value of the expected type byte: ASCII 'F'.
  localparam logic [7:0] EXPECTED_TYPE_RESET = 8'h46;

  // Largest content position; the count saturates here.
  localparam logic [5:0] POSITION_MAX = 6'h3F;

  // Number of uuid bytes minus one: the last uuid byte has this position.
  localparam logic [5:0] UUID_LAST_POS = 6'd2;

  typedef enum logic [3:0] {
    KIND_TYPE    = 4'd0,
    KIND_SHI     = 4'd1,
    KIND_SLO     = 4'd2,
    KIND_HDR     = 4'd3,
    KIND_NAME    = 4'd4,
    KIND_UUID    = 4'd5,
    KIND_TOTAL   = 4'd6,
    KIND_PART    = 4'd7,
    KIND_CONTENT = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_SHORT      = 2'd1,
    STATUS_WRONG_TYPE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ffp_in_t;

  typedef struct packed {
    kind_t       byte_kind;
    logic [5:0]  field_position;
    logic        packet_end;
    status_t     packet_status;
    logic        frame_valid;
    logic [15:0] sender_id;
    logic [1:0]  proof_kind;
    logic [5:0]  name_length;
    logic [23:0] uuid_value;
    logic [7:0]  total_parts;
    logic [7:0]  part_number;
  } ffp_out_t;

endpackage

>>> rtl/ffp_stage.sv
// ----------------------------------------------------------------------------
// File frame parser register stage
// One full-throughput valid/ready register slice for a packed beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffp_stage #(
  parameter type payload_t = logic
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  payload_t up_data,
  output logic     down_valid,
  input  logic     down_ready,
  output payload_t down_data
);

  logic     valid;
  payload_t data;

  // The slot frees as its beat leaves, so a beat can enter every cycle while down_ready is high.
  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;
  assign down_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= up_data;
    end
  end

endmodule

>>> rtl/ffp_parse.sv
// ----------------------------------------------------------------------------
// File frame parser state update
// Holds the per-packet parse state and the expected type register, and
// builds the result beat for the byte in the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [7:0]       cfg_write_data,
  input  logic             advance,
  input  ffp_pkg::ffp_in_t item,
  output ffp_pkg::ffp_out_t result
);

  import ffp_pkg::*;

  logic [7:0]  expected_type;
  kind_t       phase;
  logic [5:0]  bytes_left;
  logic [5:0]  position_count;
  logic        type_mismatch;
  logic [15:0] held_sender;
  logic [1:0]  held_proof;
  logic [5:0]  held_name_length;
  logic [23:0] held_uuid;
  logic [7:0]  held_total;
  logic [7:0]  held_part;

  kind_t       phase_next;
  logic [5:0]  bytes_left_next;
  logic [5:0]  position_count_next;
  logic        type_mismatch_next;
  logic [15:0] held_sender_next;
  logic [1:0]  held_proof_next;
  logic [5:0]  held_name_length_next;
  logic [23:0] held_uuid_next;
  logic [7:0]  held_total_next;
  logic [7:0]  held_part_next;

  kind_t       kind;
  logic [5:0]  pos;
  status_t     status;
  logic        frame_ok;

  always_comb begin
    phase_next            = phase;
    bytes_left_next       = bytes_left;
    position_count_next   = position_count;
    type_mismatch_next    = type_mismatch;
    held_sender_next      = held_sender;
    held_proof_next       = held_proof;
    held_name_length_next = held_name_length;
    held_uuid_next        = held_uuid;
    held_total_next       = held_total;
    held_part_next        = held_part;
    kind                  = phase;
    pos                   = '0;

    case (phase)
      KIND_TYPE: begin
        type_mismatch_next = (item.data_byte != expected_type);
        phase_next         = KIND_SHI;
      end
      KIND_SHI: begin
        held_sender_next = {item.data_byte, 8'h00};
        phase_next       = KIND_SLO;
      end
      KIND_SLO: begin
        held_sender_next = {held_sender[15:8], item.data_byte};
        phase_next       = KIND_HDR;
      end
      KIND_HDR: begin
        held_proof_next       = item.data_byte[7:6];
        held_name_length_next = item.data_byte[5:0];
        bytes_left_next       = item.data_byte[5:0];
        position_count_next   = '0;
        phase_next            = (item.data_byte[5:0] == '0) ? KIND_UUID : KIND_NAME;
      end
      KIND_NAME: begin
        pos                 = position_count;
        position_count_next = position_count + 6'd1;
        bytes_left_next     = bytes_left - 6'd1;
        if (bytes_left_next == '0) begin
          position_count_next = '0;
          phase_next          = KIND_UUID;
        end
      end
      KIND_UUID: begin
        pos                 = position_count;
        held_uuid_next      = {held_uuid[15:0], item.data_byte};
        position_count_next = position_count + 6'd1;
        if (position_count >= UUID_LAST_POS) begin
          position_count_next = '0;
          phase_next          = KIND_TOTAL;
        end
      end
      KIND_TOTAL: begin
        held_total_next = item.data_byte;
        phase_next      = KIND_PART;
      end
      KIND_PART: begin
        held_part_next      = item.data_byte;
        position_count_next = '0;
        phase_next          = KIND_CONTENT;
      end
      default: begin
        kind = KIND_CONTENT;
        pos  = position_count;
        if (position_count < POSITION_MAX) begin
          position_count_next = position_count + 6'd1;
        end
        phase_next = KIND_CONTENT;
      end
    endcase
  end

  // Status is judged only on the last byte; a short packet wins over a
  // wrong type when it ends before the low sender byte.
  always_comb begin
    status   = STATUS_OK;
    frame_ok = 1'b0;
    if (item.last_byte) begin
      if (kind inside {KIND_TYPE, KIND_SHI}) begin
        status = STATUS_SHORT;
      end else if (type_mismatch_next) begin
        status = STATUS_WRONG_TYPE;
      end else if (kind inside {[KIND_SLO:KIND_TOTAL]}) begin
        status = STATUS_SHORT;
      end else begin
        frame_ok = 1'b1;
      end
    end
  end

  always_comb begin
    result.byte_kind      = kind;
    result.field_position = pos;
    result.packet_end     = item.last_byte;
    result.packet_status  = status;
    result.frame_valid    = frame_ok;
    result.sender_id      = held_sender_next;
    result.proof_kind     = held_proof_next;
    result.name_length    = held_name_length_next;
    result.uuid_value     = held_uuid_next;
    result.total_parts    = held_total_next;
    result.part_number    = held_part_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type <= EXPECTED_TYPE_RESET;
    end else if (cfg_write_en) begin
      expected_type <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && item.last_byte)) begin
      phase            <= KIND_TYPE;
      bytes_left       <= '0;
      position_count   <= '0;
      type_mismatch    <= 1'b0;
      held_sender      <= '0;
      held_proof       <= '0;
      held_name_length <= '0;
      held_uuid        <= '0;
      held_total       <= '0;
      held_part        <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      bytes_left       <= bytes_left_next;
      position_count   <= position_count_next;
      type_mismatch    <= type_mismatch_next;
      held_sender      <= held_sender_next;
      held_proof       <= held_proof_next;
      held_name_length <= held_name_length_next;
      held_uuid        <= held_uuid_next;
      held_total       <= held_total_next;
      held_part        <= held_part_next;
    end
  end

endmodule

>>> rtl/file_frame_parser_core.sv
// ----------------------------------------------------------------------------
// File frame parser core
// Tags each byte of a file-transfer frame with its field and reports the
// decoded header fields and a status on the last byte of the packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The parser takes one packet byte per beat, with a flag on the final byte,
// and returns exactly one result beat for every input beat, in order. A
// frame is a type byte, a big-endian 16-bit sender, a header byte (proof
// kind in the upper two bits, name length in the lower six), the name bytes,
// a big-endian 24-bit uuid, a total-parts byte, a part-number byte and then
// content up to the end of the packet. Each result names the field its byte
// belongs to and the byte's position inside that field (content positions
// stop counting at 63), and carries every field decoded so far in the
// packet, with fields not yet reached reading as zero. On the last byte the
// status says whether the packet was too short (fewer than three bytes, or
// ended before the part number), carried a type byte other than the
// configured one, or parsed cleanly, in which case frame_valid is set. The
// parse state returns to its reset value after every last byte. Throughput
// is one byte per clock cycle while out_ready stays high. The result is
// offered from the result register; the combinational state update sits
// between the input register and the result register. Both registers are
// full-throughput slices, so a result waiting on out_ready does not stop
// the next byte from being taken as long as the result register frees in
// the same cycle. The expected type byte resets to ASCII 'F' and may be
// written through cfg_write_en and cfg_write_data while no packet byte is
// in flight.

module file_frame_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [7:0]        cfg_write_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  ffp_pkg::ffp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ffp_pkg::ffp_out_t out_data
);

  import ffp_pkg::*;

  `include "assert_macros.svh"

  // Byte held in the input register, waiting for the parser.
  logic     held_valid;
  logic     held_ready;
  ffp_in_t  held_item;

  // Combinational result for the held byte.
  ffp_out_t parse_result;

  // The parse state moves forward exactly when the held byte enters the
  // result register.
  logic     advance;

  assign advance = held_valid && held_ready;

  ffp_stage #(
    .payload_t (ffp_in_t)
  ) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .up_data    (in_data),
    .down_valid (held_valid),
    .down_ready (held_ready),
    .down_data  (held_item)
  );

  ffp_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .advance        (advance),
    .item           (held_item),
    .result         (parse_result)
  );

  ffp_stage #(
    .payload_t (ffp_out_t)
  ) u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (held_valid),
    .up_ready   (held_ready),
    .up_data    (parse_result),
    .down_valid (out_valid),
    .down_ready (out_ready),
    .down_data  (out_data)
  );

  // A clean frame is only ever reported on its last byte, after the part
  // number has been seen.
  `ASSERT_PROP(a_valid_needs_end, clk, rst,
    (out_valid && out_data.frame_valid) |-> (out_data.packet_end &&
    (out_data.byte_kind == KIND_PART || out_data.byte_kind == KIND_CONTENT)),
    "frame_valid outside a complete packet end")

  // Bytes before the end of a packet always carry the neutral status.
  `ASSERT_PROP(a_status_only_at_end, clk, rst,
    (out_valid && !out_data.packet_end) |->
    (out_data.packet_status == STATUS_OK && !out_data.frame_valid),
    "status reported before packet end")

  // A success flag and an error status never come together.
  `ASSERT_NEVER(a_valid_with_error, clk, rst,
    out_valid && out_data.frame_valid && out_data.packet_status != STATUS_OK,
    "frame_valid with an error status")

  // Both register slices are empty when reset ends, so a byte can be taken.
  `ASSERT_PROP(a_ready_after_reset, clk, rst, $fell(rst) |-> in_ready, "input not ready after reset")

endmodule
